// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 9;

    localparam logic [OP_W-1:0] OP_INSERT       = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_HEAD     = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_EXACT    = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_AT_LEAST = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

    localparam logic [DATA_W-1:0] FAIL_DATA = '1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } cmd_t;

    // per-cell compare results, all qualified by the cell holding an entry
    typedef struct packed {
        logic stop;
        logic gt;
        logic eq;
        logic ge;
    } flags_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } commit_t;

    localparam flags_t LEFT_EDGE = '{stop: 1'b1, gt: 1'b0, eq: 1'b0, ge: 1'b0};

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_t             cmd,
    input  wire logic [CNT_W-1:0] count,
    input  wire commit_t          ctl,
    input  wire flags_t           left_flags,
    input  wire entry_t           left_ent,
    input  wire entry_t           right_ent,
    output flags_t                flags,
    output entry_t                ent,
    output logic                  hit
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   valid;
    logic   right_valid;
    logic   le;
    logic   ge;
    logic   shift_left;

    assign valid       = CNT_W'(IDX) < count;
    assign right_valid = (IDX + 1) < int'(count);
    assign le          = $signed(ent_reg.prio) <= $signed(cmd.prio);
    assign ge          = $signed(ent_reg.prio) >= $signed(cmd.prio);

    assign flags.stop = valid && le;
    assign flags.gt   = valid && !le;
    assign flags.eq   = valid && (ent_reg.prio == cmd.prio);
    assign flags.ge   = valid && ge;

    assign shift_left = (cmd.op == OP_POP_HEAD) || !valid || ge;

    always_comb begin
        case (cmd.op)
            OP_POP_HEAD:     hit = (IDX == 0) && valid;
            OP_POP_EXACT:    hit = flags.eq && !left_flags.eq;
            OP_POP_AT_LEAST: hit = flags.ge && !left_flags.ge;
            default:         hit = 1'b0;
        endcase
    end

    always_comb begin
        ent_next = ent_reg;
        if (ctl.ins) begin
            if (left_flags.gt) begin
                ent_next = left_ent;
            end else if (left_flags.stop && !flags.stop) begin
                ent_next.data = cmd.data;
                ent_next.prio = cmd.prio;
            end
        end else if (ctl.rem && shift_left) begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

    // held entries stay in ascending priority order
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        right_valid |-> ($signed(ent_reg.prio) <= $signed(right_ent.prio)))
        else $error("spq_cell: neighbor entries out of order");

endmodule

`default_nettype wire

// ===== rtl/spq_sel_tree.sv =====
`default_nettype none

module spq_sel_tree
    import spq_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic              aclk,
    input  wire logic [DEPTH-1:0]  hit,
    input  wire entry_t            ent [DEPTH],
    output logic                   found,
    output logic [DATA_W-1:0]      data
);

    localparam int GRP  = 16;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    logic [NGRP-1:0]   grp_found_next;
    logic [NGRP-1:0]   grp_found_reg;
    logic [DATA_W-1:0] grp_data_next [NGRP];
    logic [DATA_W-1:0] grp_data_reg  [NGRP];
    logic              found_next;
    logic              found_reg;
    logic [DATA_W-1:0] data_next;
    logic [DATA_W-1:0] data_reg;

    // first level: and-or select inside each group of cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_found_next[g] = 1'b0;
            grp_data_next[g]  = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < DEPTH) begin
                    if (hit[g * GRP + k]) begin
                        grp_found_next[g] = 1'b1;
                        grp_data_next[g]  = grp_data_next[g] | ent[g * GRP + k].data;
                    end
                end
            end
        end
    end

    // second level: across groups
    always_comb begin
        found_next = |grp_found_reg;
        data_next  = '0;
        for (int g = 0; g < NGRP; g++) begin
            data_next = data_next | grp_data_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        grp_found_reg <= grp_found_next;
        grp_data_reg  <= grp_data_next;
        found_reg     <= found_next;
        data_reg      <= data_next;
    end

    assign found = found_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of up to DEPTH (data, priority) entries, kept in ascending signed
// priority order (smaller is more urgent, equal priorities in arrival order) in a row of
// cells that each hold one entry and exchange entries with their neighbors. Each item is
// one operation: insert, pop head, pop exact priority, or pop first entry at or above a
// priority. Every item gives exactly one result with data, status and the occupancy
// after the operation. One item is worked on at a time: an insert, or a removal from an
// empty queue, is accepted into a command register and has its result loaded into the
// output register from the execute state, after which the next item can be accepted; any
// other removal goes on through a wait state and a commit state, because the removed
// payload is gathered from the cells through a two-level registered select tree before
// the row shifts. A result waits in an output register, and the next item may be accepted
// meanwhile; it completes once that register is free.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [OP_W-1:0]   s_operation,
    input  wire logic [DATA_W-1:0] s_data_in,
    input  wire logic [PRIO_W-1:0] s_priority_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_data_out,
    output logic [STAT_W-1:0]      m_status,
    output logic [OCC_W-1:0]       m_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    cmd_t              cmd_reg;
    commit_t           ctl;
    logic              out_free;
    logic              out_load;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] data_out_reg, data_out_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [OCC_W-1:0]  occ_reg;

    entry_t            ent [DEPTH];
    flags_t            flg [DEPTH];
    logic [DEPTH-1:0]  hit;
    logic              sel_found;
    logic [DATA_W-1:0] sel_data;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            flags_t lf;
            entry_t le;
            entry_t re;
            if (i == 0) begin : g_first
                assign lf = LEFT_EDGE;
                assign le = ent[i];
            end else begin : g_inner
                assign lf = flg[i-1];
                assign le = ent[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign re = ent[i];
            end else begin : g_mid
                assign re = ent[i+1];
            end
            spq_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd_reg),
                .count      (count_reg),
                .ctl        (ctl),
                .left_flags (lf),
                .left_ent   (le),
                .right_ent  (re),
                .flags      (flg[i]),
                .ent        (ent[i]),
                .hit        (hit[i])
            );
        end
    endgenerate

    spq_sel_tree #(
        .DEPTH (DEPTH)
    ) u_sel_tree (
        .aclk  (aclk),
        .hit   (hit),
        .ent   (ent),
        .found (sel_found),
        .data  (sel_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ctl           = '0;
        out_load      = 1'b0;
        data_out_next = '0;
        status_next   = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd_reg.op == OP_INSERT) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                        if (count_reg == CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            ctl.ins    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end else if (count_reg == '0) begin
                    if (out_free) begin
                        out_load      = 1'b1;
                        status_next   = ST_EMPTY;
                        data_out_next = FAIL_DATA;
                        state_next    = S_IDLE;
                    end
                end else begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (sel_found) begin
                        ctl.rem       = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                        data_out_next = sel_data;
                    end else begin
                        status_next   = ST_NOMATCH;
                        data_out_next = FAIL_DATA;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg.op   <= s_operation;
            cmd_reg.data <= s_data_in;
            cmd_reg.prio <= s_priority_req;
        end
        if (out_load) begin
            data_out_reg <= data_out_next;
            status_reg   <= status_next;
            occ_reg      <= OCC_W'(count_next);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_data_out  = data_out_reg;
    assign m_status    = status_reg;
    assign m_occupancy = occ_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("sorted_priority_queue: entry count above depth");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> $onehot0(hit))
        else $error("sorted_priority_queue: more than one cell selected");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg == ST_FULL)) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("sorted_priority_queue: full reported below depth");

    a_count_at_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != count_next) |-> out_load)
        else $error("sorted_priority_queue: count changed without a result");

endmodule

`default_nettype wire
